// ----- hdl/mdc_pkg.sv -----
package mdc_pkg;
  localparam int SUMXY_W = 58;
  localparam int SUMZ_W  = 41;
  localparam int CNT_W   = 25;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 25'h1000000;

  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_TOL     = 3'd1;
  localparam logic [2:0] REG_MIN_D   = 3'd2;
  localparam logic [2:0] REG_MAX_D   = 3'd3;
  localparam logic [2:0] REG_MIN_PTS = 3'd4;
  localparam logic [2:0] REG_FX      = 3'd5;
  localparam logic [2:0] REG_FY      = 3'd6;
  localparam logic [2:0] REG_PP      = 3'd7;

  typedef struct packed {
    logic signed [SUMXY_W-1:0] sum_x;
    logic signed [SUMXY_W-1:0] sum_y;
    logic [SUMZ_W-1:0]         sum_z;
    logic [CNT_W-1:0]          cnt;
  } frame_sums_t;

  typedef struct packed {
    logic               found;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic [15:0]        mean_z;
    logic [CNT_W-1:0]   cnt;
  } frame_res_t;
endpackage

// ----- hdl/masked_depth_centroid_unit.sv -----
// Front pipeline: classification and products are registered, then summed; a frame result
// is formed after the transfer of its last pixel by three serial 58-bit divisions plus setup.
// Throughput: one pixel per cycle while full is low; the divider works on one frame at a time;
// up to three finished frames may wait in the queue between accumulator and divider.
// Reset: synchronous active-low rst_n clears sums, queue, sequencer and registers.
module masked_depth_centroid_unit
  import mdc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_pixel_blue,
  input  logic [7:0]         in_pixel_green,
  input  logic [7:0]         in_pixel_red,
  input  logic [15:0]        in_depth_mm,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic               in_last_of_frame,
  output logic               empty,
  input  logic               pop,
  output logic               out_found,
  output logic signed [23:0] out_mean_x_mm,
  output logic signed [23:0] out_mean_y_mm,
  output logic [15:0]        out_mean_z_mm,
  output logic [24:0]        out_counted_pixels,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  // Configuration registers, written directly by index.
  logic [23:0] target_r;
  logic [7:0]  tol_r;
  logic [15:0] min_d_r, max_d_r, fx_r, fy_r;
  logic [24:0] min_pts_r;
  logic [31:0] pp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= 24'hFFEB04; tol_r <= 8'd10; min_d_r <= 16'd100;
      max_d_r <= 16'd25000; min_pts_r <= 25'd20; fx_r <= '0; fy_r <= '0;
      pp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:  target_r  <= cfg_data[23:0];
        REG_TOL:     tol_r     <= cfg_data[7:0];
        REG_MIN_D:   min_d_r   <= cfg_data[15:0];
        REG_MAX_D:   max_d_r   <= cfg_data[15:0];
        REG_MIN_PTS: min_pts_r <= cfg_data[24:0];
        REG_FX:      fx_r      <= cfg_data[15:0];
        REG_FY:      fy_r      <= cfg_data[15:0];
        REG_PP:      pp_r      <= cfg_data;
        default:     ;
      endcase
    end
  end

  // The queue of finished frames is held below its depth by stalling pixel
  // transfers: full rises while three frames are queued or in flight.
  logic        frm_vld, q_ne, job_take, res_vld;
  frame_sums_t frm_sums, q_data;
  frame_res_t  res;
  logic [2:0]  pend_r;
  logic        acc;
  assign acc = push && !full;
  assign full = pend_r >= 3'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_r + {2'b00, acc && in_last_of_frame} - {2'b00, job_take};
  end

  mdc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .pix_vld(acc), .pix_b(in_pixel_blue),
    .pix_g(in_pixel_green), .pix_r(in_pixel_red), .pix_d(in_depth_mm),
    .pix_u(in_column), .pix_v(in_row), .pix_last(in_last_of_frame),
    .target_color(target_r), .tolerance(tol_r), .min_d(min_d_r),
    .max_d(max_d_r), .pp(pp_r), .frm_vld(frm_vld), .frm_sums(frm_sums)
  );

  mdc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(frm_vld), .wdata(frm_sums),
    .rd(job_take), .nonempty(q_ne), .rdata(q_data)
  );

  mdc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(q_ne), .job(q_data), .job_take(job_take),
    .min_pts(min_pts_r), .focal_x(fx_r), .focal_y(fy_r),
    .res_vld(res_vld), .res(res), .res_take(pop)
  );

  assign empty              = !res_vld;
  assign out_found          = res.found;
  assign out_mean_x_mm      = res.mean_x;
  assign out_mean_y_mm      = res.mean_y;
  assign out_mean_z_mm      = res.mean_z;
  assign out_counted_pixels = res.cnt;
endmodule

// ----- hdl/mdc_front.sv -----
module mdc_front
  import mdc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pix_vld,
  input  logic [7:0]         pix_b,
  input  logic [7:0]         pix_g,
  input  logic [7:0]         pix_r,
  input  logic [15:0]        pix_d,
  input  logic [11:0]        pix_u,
  input  logic [11:0]        pix_v,
  input  logic               pix_last,
  input  logic [23:0]        target_color,
  input  logic [7:0]         tolerance,
  input  logic [15:0]        min_d,
  input  logic [15:0]        max_d,
  input  logic [31:0]        pp,
  output logic               frm_vld,
  output frame_sums_t        frm_sums
);
  // Stage 1: classification and products registered; stage 2: accumulate.
  // Coordinates keep their low COORD_BITS bits; wider settings keep all 12.
  localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

  logic                     s1_vld_r, s1_hit_r, s1_last_r;
  logic signed [33:0]       s1_px_r, s1_py_r;
  logic [15:0]              s1_d_r;
  logic signed [SUMXY_W-1:0] sx_r, sy_r;
  logic [SUMZ_W-1:0]        sz_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     frm_vld_r;
  frame_sums_t              frm_r;

  function automatic logic ch_ok(input logic [7:0] p, input logic [7:0] t,
                                 input logic [7:0] tol);
    logic [7:0] gap;
    gap = (p > t) ? p - t : t - p;
    return gap <= tol;
  endfunction

  logic hit;
  logic signed [17:0] du, dv;
  logic [11:0] u_c, v_c;
  assign u_c = pix_u & CMASK;
  assign v_c = pix_v & CMASK;
  assign hit = ch_ok(pix_b, target_color[7:0], tolerance)
            && ch_ok(pix_g, target_color[15:8], tolerance)
            && ch_ok(pix_r, target_color[23:16], tolerance)
            && pix_d != 16'd0 && pix_d >= min_d && pix_d <= max_d;
  assign du = $signed({2'b00, 16'(u_c) << 4}) - $signed({2'b00, pp[15:0]});
  assign dv = $signed({2'b00, 16'(v_c) << 4}) - $signed({2'b00, pp[31:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pix_vld;
    end
    s1_hit_r  <= hit;
    s1_last_r <= pix_last;
    s1_d_r    <= pix_d;
    s1_px_r   <= du * $signed({1'b0, pix_d});
    s1_py_r   <= dv * $signed({1'b0, pix_d});
  end

  logic take;
  logic signed [SUMXY_W-1:0] sx_nxt, sy_nxt;
  logic [SUMZ_W-1:0] sz_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  assign take = s1_vld_r && s1_hit_r && (cnt_r < COUNT_LIMIT);
  always_comb begin
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r; cnt_nxt = cnt_r;
    if (take) begin
      sx_nxt  = sx_r + SUMXY_W'(s1_px_r);
      sy_nxt  = sy_r + SUMXY_W'(s1_py_r);
      sz_nxt  = sz_r + SUMZ_W'(s1_d_r);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0; cnt_r <= '0;
      frm_vld_r <= 1'b0;
    end else begin
      frm_vld_r <= s1_vld_r && s1_last_r;
      if (s1_vld_r && s1_last_r) begin
        sx_r <= '0; sy_r <= '0; sz_r <= '0; cnt_r <= '0;
      end else begin
        sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt; cnt_r <= cnt_nxt;
      end
    end
    frm_r <= '{sum_x: sx_nxt, sum_y: sy_nxt, sum_z: sz_nxt, cnt: cnt_nxt};
  end

  assign frm_vld  = frm_vld_r;
  assign frm_sums = frm_r;
endmodule

// ----- hdl/mdc_fifo.sv -----
module mdc_fifo
  import mdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  frame_sums_t wdata,
  input  logic        rd,
  output logic        nonempty,
  output frame_sums_t rdata
);
  // Four-entry queue of finished frame sums.
  frame_sums_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      n_r <= n_r + {2'b00, wr} - {2'b00, rd};
    end
    if (wr) mem[wp_r] <= wdata;
  end
  assign nonempty = n_r != 3'd0;
  assign rdata    = mem[rp_r];
endmodule

// ----- hdl/mdc_div.sv -----
module mdc_div #(
  parameter int NW = 58,
  parameter int DW = 41
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);
  // Restoring divider, one quotient bit per cycle, unsigned.
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] k_r;
  logic          busy_r;
  logic [DW:0]   trial;
  assign trial = {rem_r[DW-1:0], q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= CW'(NW);
      q_r    <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
      k_r <= k_r - 1'b1;
      if (k_r == CW'(1)) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;
  assign quo  = q_r;
endmodule

// ----- hdl/mdc_back.sv -----
module mdc_back
  import mdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_vld,
  input  frame_sums_t job,
  output logic        job_take,
  input  logic [24:0] min_pts,
  input  logic [15:0] focal_x,
  input  logic [15:0] focal_y,
  output logic        res_vld,
  output frame_res_t  res,
  input  logic        res_take
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_DX = 5'b00010, ST_DY = 5'b00100,
    ST_DZ = 5'b01000, ST_OUT = 5'b10000
  } st_t;
  st_t st_r, st_nxt;
  frame_sums_t j_r;
  frame_res_t  res_r;
  logic [40:0] den_r;
  logic        go_r, started_r;
  logic        dv_busy;
  logic [57:0] dv_quo;
  logic [57:0] num;
  logic        neg;
  logic [40:0] den_x, den_y;

  // Denominator products count * focal, one multiply per term, formed as the
  // job is taken so that they are ready when the first division starts.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && job_vld) begin
      den_x <= job.cnt * focal_x;
      den_y <= job.cnt * focal_y;
    end
  end

  assign neg = (st_r == ST_DX) ? j_r.sum_x[57] :
               (st_r == ST_DY) ? j_r.sum_y[57] : 1'b0;
  always_comb begin
    unique case (st_r)
      ST_DX:   num = j_r.sum_x[57] ? 58'(-j_r.sum_x) : j_r.sum_x;
      ST_DY:   num = j_r.sum_y[57] ? 58'(-j_r.sum_y) : j_r.sum_y;
      default: num = 58'(j_r.sum_z);
    endcase
  end

  mdc_div #(.NW(58), .DW(41)) u_div (
    .clk(clk), .rst_n(rst_n), .start(go_r), .num(num), .den(den_r),
    .busy(dv_busy), .quo(dv_quo)
  );

  logic done;
  assign done = started_r && !go_r && !dv_busy;

  function automatic logic [23:0] sat(input logic [57:0] mag, input logic ng,
                                      input logic zero);
    if (zero) return 24'd0;
    if (ng) return (mag > 58'd8388608) ? 24'h800000 : 24'(-mag);
    return (mag > 58'd8388607) ? 24'h7FFFFF : mag[23:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_vld) st_nxt = ST_DX;
      ST_DX:   if (done) st_nxt = ST_DY;
      ST_DY:   if (done) st_nxt = ST_DZ;
      ST_DZ:   if (done) st_nxt = ST_OUT;
      ST_OUT:  if (res_take) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; go_r <= 1'b0; started_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      go_r <= 1'b0;
      if (st_r == ST_IDLE && job_vld) begin
        started_r <= 1'b0;
      end else if (st_r == ST_DX || st_r == ST_DY || st_r == ST_DZ) begin
        if (!started_r && !go_r) begin
          // Register the start so that the divider sees the loaded denominator register.
          go_r <= 1'b1;
          started_r <= 1'b1;
        end else if (done) begin
          started_r <= 1'b0;
        end
      end
    end
    if (st_r == ST_IDLE && job_vld) j_r <= job;
    unique case (st_r)
      ST_DX:   den_r <= den_x;
      ST_DY:   den_r <= den_y;
      default: den_r <= 41'(j_r.cnt);
    endcase
    if (st_r == ST_DX && done)
      res_r.mean_x <= sat(dv_quo, neg, den_r == 41'd0);
    if (st_r == ST_DY && done)
      res_r.mean_y <= sat(dv_quo, neg, den_r == 41'd0);
    if (st_r == ST_DZ && done) begin
      res_r.mean_z <= (den_r == 41'd0) ? 16'd0 : dv_quo[15:0];
      res_r.cnt    <= j_r.cnt;
      res_r.found  <= j_r.cnt >= min_pts && focal_x != 16'd0 && focal_y != 16'd0;
    end
  end

  assign job_take = (st_r == ST_IDLE) && job_vld;
  assign res_vld  = (st_r == ST_OUT);
  assign res      = res_r;
endmodule
